[rtl/core/dsga_pkg.sv]
`default_nettype none
package dsga_pkg;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_ADD,
        ST_SOFT,
        ST_NORM,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_RECIP_GO,
        ST_RECIP_WAIT,
        ST_QUOT_GO,
        ST_QUOT_WAIT,
        ST_POT,
        ST_W2_MUL,
        ST_W3_MUL,
        ST_MW_MUL,
        ST_MW_GET,
        ST_LO_MUL,
        ST_HI_MUL,
        ST_AXIS,
        ST_EMIT
    } dsga_state_t;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned SUM_W   = 48;
    localparam int unsigned DIST_W  = 67;
    localparam int unsigned DIV_W   = 64;
    localparam int unsigned ROOT_W  = 32;

    localparam logic [SUM_W-1:0] POT_MAX   = {SUM_W{1'b1}};
    localparam logic [SUM_W-2:0] ACC_MAG_MAX = {(SUM_W-1){1'b1}};
    localparam logic signed [SUM_W-1:0] ACC_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // numerator of the reciprocal: 2^61
    localparam logic [DIV_W-1:0] RECIP_NUM = 64'h2000_0000_0000_0000;

endpackage
`default_nettype wire

[rtl/core/dsga_mul.sv]
`default_nettype none
module dsga_mul (
    input  wire logic        aclk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [63:0] p
);
    // registered 32x32 unsigned product
    logic [63:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule
`default_nettype wire

[rtl/core/dsga_div.sv]
`default_nettype none
module dsga_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [31:0] den,
    output logic             busy,
    output logic      [63:0] quo
);
    // restoring divider, one quotient bit per cycle
    logic [63:0] num_reg, quo_reg;
    logic [31:0] den_reg, rem_reg;
    logic [6:0]  cnt_reg;
    logic [32:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_reg, num_reg[63]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= 7'd64;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (cnt_reg != '0) begin
            num_reg <= {num_reg[62:0], 1'b0};
            rem_reg <= ge ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    assign busy = cnt_reg != '0;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

[rtl/core/dsga_isqrt.sv]
`default_nettype none
module dsga_isqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             busy,
    output logic      [31:0] root
);
    // digit-by-digit integer square root, one result bit per cycle
    logic [63:0] x_reg, res_reg, bit_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] trial;
    logic        take;

    assign trial = res_reg + bit_reg;
    assign take  = x_reg >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= 6'd32;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end else if (cnt_reg != '0) begin
            if (take) begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = cnt_reg != '0;
    assign root = res_reg[31:0];
endmodule
`default_nettype wire

[rtl/core/direct_sum_gravity_accumulator_top.sv]
// Softened direct-sum gravity accumulator.
// s_ channel: one transaction per neighbour; s_tdata carries the target position,
// the neighbour position and mass, s_tlast closes a target's neighbour list.
// m_ channel: one transaction per list, the acceleration and potential sums
// (including the last neighbour) plus a clip flag in m_tuser.
// cfg_we/cfg_wdata write the softening term; write it only while idle.
// Each neighbour runs through the whole sequence before the next transaction is
// accepted. One 64-step shared divider runs twice (reciprocal root and mass/root),
// a 32-step root unit once, a 2-bit-per-cycle normalizer brings the distance into
// range, and one shared 32x32 multiplier handles all products. s_tready is high
// only while idle.
// A result sits in an output register; while the receiver stalls, the next
// list can be accumulated, and only its own emission waits for the register.
// Reset clears the sums and the clip flag, drops m_tvalid and sets the
// softening term to 1.
`default_nettype none
module direct_sum_gravity_accumulator_top #(
    parameter int DIMS = 3
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // target_x, target_y, target_z, neighbour_x, neighbour_y, neighbour_z, neighbour_mass
    input  wire logic [223:0] s_tdata,
    input  wire logic         s_tlast,   // last_neighbour
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // accel_x, accel_y, accel_z, potential
    output logic      [191:0] m_tdata,
    output logic              m_tuser    // saturated
);
    import dsga_pkg::*;

    localparam logic [1:0] LAST_AXIS = 2'(DIMS - 1);

    dsga_state_t state_reg, state_next;

    logic [31:0] soft_reg;
    logic [31:0] mag_reg [3];
    logic [2:0]  neg_reg;
    logic [31:0] mass_reg;
    logic        last_reg;
    logic [1:0]  axis_reg;
    logic [DIST_W-1:0] dist_reg;
    logic signed [5:0] exp_reg;
    logic [31:0] root_reg, recip_reg;
    logic [33:0] quot_reg;
    logic [63:0] mw_reg, lo_reg;

    logic signed [SUM_W-1:0] accel_reg [3];
    logic [SUM_W-1:0] pot_reg;
    logic             clip_reg;

    logic [191:0] out_data_reg;
    logic         out_sat_reg, out_valid_reg;

    // shared units
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic        div_start, div_busy;
    logic [63:0] div_num, div_quo;
    logic [31:0] div_den;
    logic        root_start, root_busy;
    logic [31:0] root_res;

    dsga_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .p(mul_p));

    dsga_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(div_den), .busy(div_busy), .quo(div_quo)
    );

    dsga_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .start(root_start),
        .radicand({2'b00, dist_reg[61:0]}), .busy(root_busy), .root(root_res)
    );

    // input offsets and magnitudes
    logic [31:0] in_mag [3];
    logic [2:0]  in_neg;
    logic        accept;

    always_comb begin
        logic [31:0] tc, nc;
        logic [32:0] diff;
        for (int k = 0; k < 3; k++) begin
            tc   = s_tdata[32*k +: 32];
            nc   = s_tdata[96 + 32*k +: 32];
            diff = {nc[31], nc} - {tc[31], tc};
            if (k < DIMS) begin
                in_neg[k] = diff[32];
                in_mag[k] = diff[32] ? 32'(-diff) : diff[31:0];
            end else begin
                in_neg[k] = 1'b0;
                in_mag[k] = '0;
            end
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;

    logic emit_load;
    assign emit_load = (state_reg == ST_EMIT) && last_reg && !(out_valid_reg && !m_tready);

    // potential term: q * 2^-(7+e), clipped
    logic [7:0]  exp_ext;
    logic [5:0]  pot_sh;
    logic [56:0] pot_shifted;
    logic [SUM_W-1:0] pot_term;
    logic        pot_term_clip;
    logic [SUM_W:0] pot_sum;

    assign exp_ext       = {{2{exp_reg[5]}}, exp_reg};
    assign pot_sh        = 6'(8'd30 + exp_ext);
    assign pot_shifted   = {quot_reg, 23'b0} >> pot_sh;
    assign pot_term_clip = |pot_shifted[56:48];
    assign pot_term      = pot_term_clip ? POT_MAX : pot_shifted[47:0];
    assign pot_sum       = {1'b0, pot_reg} + {1'b0, pot_term};

    // acceleration term: mw*|dr| * 2^-(81+3e), clipped, signed
    logic [95:0]  acc_prod;
    logic [6:0]   acc_sh;
    logic [104:0] acc_shifted;
    logic [SUM_W-2:0] acc_term;
    logic         acc_term_clip;
    logic signed [SUM_W:0] acc_signed, acc_sum;
    logic signed [SUM_W-1:0] acc_cur, acc_new;
    logic         acc_sum_clip;

    assign acc_prod      = {mul_p, 32'b0} + {32'b0, lo_reg};
    assign acc_sh        = 7'(8'd90 + exp_ext + exp_ext + exp_ext);
    assign acc_shifted   = {acc_prod, 9'b0} >> acc_sh;
    assign acc_term_clip = |acc_shifted[104:47];
    assign acc_term      = acc_term_clip ? ACC_MAG_MAX : acc_shifted[46:0];
    assign acc_cur       = accel_reg[axis_reg];
    assign acc_signed    = neg_reg[axis_reg] ? -$signed({2'b00, acc_term})
                                             : $signed({2'b00, acc_term});
    assign acc_sum       = $signed({acc_cur[SUM_W-1], acc_cur}) + acc_signed;
    assign acc_sum_clip  = acc_sum[SUM_W] != acc_sum[SUM_W-1];

    always_comb begin
        if (!acc_sum_clip) begin
            acc_new = acc_sum[SUM_W-1:0];
        end else if (acc_sum[SUM_W]) begin
            acc_new = ACC_MIN;
        end else begin
            acc_new = ACC_MAX;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (accept) state_next = ST_SQ_MUL;
            ST_SQ_MUL:     state_next = ST_SQ_ADD;
            ST_SQ_ADD:     state_next = (axis_reg == LAST_AXIS) ? ST_SOFT : ST_SQ_MUL;
            ST_SOFT:       state_next = ST_NORM;
            ST_NORM: begin
                if (dist_reg[66:62] == '0 && dist_reg[61:60] != '0) state_next = ST_ROOT_GO;
            end
            ST_ROOT_GO:    state_next = ST_ROOT_WAIT;
            ST_ROOT_WAIT:  if (!root_busy) state_next = ST_RECIP_GO;
            ST_RECIP_GO:   state_next = ST_RECIP_WAIT;
            ST_RECIP_WAIT: if (!div_busy) state_next = ST_QUOT_GO;
            ST_QUOT_GO:    state_next = ST_QUOT_WAIT;
            ST_QUOT_WAIT:  if (!div_busy) state_next = ST_POT;
            ST_POT:        state_next = ST_W2_MUL;
            ST_W2_MUL:     state_next = ST_W3_MUL;
            ST_W3_MUL:     state_next = ST_MW_MUL;
            ST_MW_MUL:     state_next = ST_MW_GET;
            ST_MW_GET:     state_next = ST_LO_MUL;
            ST_LO_MUL:     state_next = ST_HI_MUL;
            ST_HI_MUL:     state_next = ST_AXIS;
            ST_AXIS:       state_next = (axis_reg == LAST_AXIS) ? ST_EMIT : ST_LO_MUL;
            ST_EMIT: begin
                if (!last_reg || emit_load) state_next = ST_IDLE;
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // unit operands and starts
    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_num    = RECIP_NUM;
        div_den    = root_reg;
        root_start = 1'b0;
        unique case (state_reg)
            ST_SQ_MUL: begin
                mul_a = mag_reg[axis_reg];
                mul_b = mag_reg[axis_reg];
            end
            ST_ROOT_GO:  root_start = 1'b1;
            ST_RECIP_GO: div_start = 1'b1;
            ST_QUOT_GO: begin
                div_start = 1'b1;
                div_num   = {1'b0, mass_reg, 31'b0};
            end
            ST_W2_MUL: begin
                mul_a = recip_reg;
                mul_b = recip_reg;
            end
            ST_W3_MUL: begin
                mul_a = mul_p[62:31];
                mul_b = recip_reg;
            end
            ST_MW_MUL: begin
                mul_a = mass_reg;
                mul_b = mul_p[62:31];
            end
            ST_LO_MUL: begin
                mul_a = mw_reg[31:0];
                mul_b = mag_reg[axis_reg];
            end
            ST_HI_MUL: begin
                mul_a = mw_reg[63:32];
                mul_b = mag_reg[axis_reg];
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // control state and accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            soft_reg      <= 32'd1;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++) accel_reg[k] <= '0;
            pot_reg       <= '0;
            clip_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) soft_reg <= cfg_wdata;

            if (emit_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (state_reg == ST_POT) begin
                pot_reg  <= pot_sum[SUM_W] ? POT_MAX : pot_sum[SUM_W-1:0];
                clip_reg <= clip_reg | pot_term_clip | pot_sum[SUM_W];
            end else if (state_reg == ST_AXIS) begin
                accel_reg[axis_reg] <= acc_new;
                clip_reg <= clip_reg | acc_term_clip | acc_sum_clip;
            end else if (emit_load) begin
                for (int k = 0; k < 3; k++) accel_reg[k] <= '0;
                pot_reg  <= '0;
                clip_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    for (int k = 0; k < 3; k++) mag_reg[k] <= in_mag[k];
                    neg_reg  <= in_neg;
                    mass_reg <= s_tdata[223:192];
                    last_reg <= s_tlast;
                    axis_reg <= '0;
                    dist_reg <= '0;
                    exp_reg  <= '0;
                end
            end
            ST_SQ_ADD: begin
                dist_reg <= dist_reg + {3'b000, mul_p};
                axis_reg <= (axis_reg == LAST_AXIS) ? 2'd0 : axis_reg + 2'd1;
            end
            ST_SOFT: begin
                if (dist_reg == '0 && soft_reg == '0) begin
                    dist_reg <= DIST_W'(1);
                end else begin
                    dist_reg <= dist_reg + {35'b0, soft_reg};
                end
            end
            ST_NORM: begin
                if (dist_reg[66:62] != '0) begin
                    dist_reg <= dist_reg >> 2;
                    exp_reg  <= exp_reg + 6'sd1;
                end else if (dist_reg[61:60] == '0) begin
                    dist_reg <= dist_reg << 2;
                    exp_reg  <= exp_reg - 6'sd1;
                end
            end
            ST_ROOT_WAIT:  if (!root_busy) root_reg <= root_res;
            ST_RECIP_WAIT: if (!div_busy) recip_reg <= div_quo[31:0];
            ST_QUOT_WAIT:  if (!div_busy) quot_reg <= div_quo[33:0];
            ST_MW_GET:     mw_reg <= mul_p;
            ST_HI_MUL:     lo_reg <= mul_p;
            ST_AXIS:       axis_reg <= (axis_reg == LAST_AXIS) ? 2'd0 : axis_reg + 2'd1;
            ST_EMIT: begin
                if (emit_load) begin
                    out_data_reg <= {pot_reg, accel_reg[2], accel_reg[1], accel_reg[0]};
                    out_sat_reg  <= clip_reg;
                end
            end
            default: begin
                lo_reg <= lo_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

    // checks
    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROOT_GO |-> dist_reg[66:62] == '0 && dist_reg[61:60] != '0)
        else $error("normalized distance out of range");

    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RECIP_GO |-> root_reg[31:30] == 2'b01)
        else $error("root out of expected range");

    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load |=> pot_reg == '0 && !clip_reg && m_tvalid)
        else $error("sums not cleared after emission");

    a_units_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !div_busy && !root_busy)
        else $error("shared unit busy while idle");

    a_unused_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |-> (DIMS >= 3) || (accel_reg[2] == '0))
        else $error("unused axis accumulated");

endmodule
`default_nettype wire

[dv/tb.sv]
`default_nettype none

// Expected sums per neighbour list, with the running accumulator state.
class gravity_sums;
    logic signed [47:0] acc_sum [3];
    logic [47:0]        pot_sum;
    bit                 clip;
    logic [31:0]        soft_sq;
    int                 dims;
    logic [192:0]       sums_q [$];
    int                 n_err;

    function new(int d);
        dims = d;
        soft_sq = 32'd1;
        clear_sums();
        n_err = 0;
    endfunction

    function void clear_sums();
        for (int k = 0; k < 3; k++) acc_sum[k] = '0;
        pot_sum = '0;
        clip = 0;
    endfunction

    static function int bit_len(logic [127:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 128; i++) if (v[i]) n = i + 1;
        return n;
    endfunction

    static function logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // Scale by 2^-s with truncation, clip to limit.
    static function logic [63:0] scale_clip(logic [127:0] v, int s, logic [63:0] limit,
                                             ref bit sat);
        logic [127:0] t;
        if (s < 0) begin
            if (-s > 63 || v > ({64'd0, limit} >> (-s))) begin
                sat = 1;
                return limit;
            end
            return v[63:0] << (-s);
        end
        t = (s >= 128) ? '0 : (v >> s);
        if (t > {64'd0, limit}) begin
            sat = 1;
            return limit;
        end
        return t[63:0];
    endfunction

    // Accepted neighbour transaction: accumulate, and on the last one queue the sums.
    function void note_neighbour(logic [223:0] d, bit last);
        logic signed [33:0] dr [3];
        logic [63:0]  mag [3];
        logic [127:0] dsq, prod;
        logic [63:0]  dn, r, w, w2, w3, q, term, m, mw;
        logic signed [49:0] s;
        bit sat;
        int len, e;
        sat = 0;
        dsq = '0;
        m = {32'd0, d[192 +: 32]};
        for (int k = 0; k < 3; k++) begin
            dr[k] = 0;
            mag[k] = 0;
            if (k < dims) begin
                dr[k] = $signed(d[(3+k)*32 +: 32]) - $signed(d[k*32 +: 32]);
                mag[k] = dr[k] < 0 ? 64'(-dr[k]) : 64'(dr[k]);
                dsq = dsq + mag[k] * mag[k];
            end
        end
        dsq = dsq + soft_sq;
        if (dsq == 0) dsq = 1;
        len = bit_len(dsq);
        e = ((len + 1) >> 1) - 31;
        dn = (e > 0) ? 64'(dsq >> (2 * e)) : 64'(dsq << (-2 * e));
        r = int_sqrt(dn);
        if (r == 0) r = 1;
        w = (64'd1 << 61) / r;
        w2 = (w * w) >> 31;
        w3 = (w2 * w) >> 31;
        q = (m << 31) / r;
        term = scale_clip({64'd0, q}, 7 + e, 64'hFFFF_FFFF_FFFF, sat);
        if ({1'b0, pot_sum} + {1'b0, term[47:0]} > 49'hFFFF_FFFF_FFFF) begin
            pot_sum = '1;
            sat = 1;
        end else begin
            pot_sum = pot_sum + term[47:0];
        end
        mw = m * w3;
        for (int k = 0; k < dims && k < 3; k++) begin
            prod = {64'd0, mw} * {64'd0, mag[k]};
            term = scale_clip(prod, 81 + 3 * e, 64'h7FFF_FFFF_FFFF, sat);
            s = acc_sum[k] + (dr[k] < 0 ? -$signed({2'b0, term[47:0]})
                                        : $signed({2'b0, term[47:0]}));
            if (s > 50'sh7FFF_FFFF_FFFF) begin
                s = 50'sh7FFF_FFFF_FFFF;
                sat = 1;
            end
            if (s < -50'sh8000_0000_0000) begin
                s = -50'sh8000_0000_0000;
                sat = 1;
            end
            acc_sum[k] = s[47:0];
        end
        if (sat) clip = 1;
        if (last) begin
            sums_q.push_back({clip, pot_sum, acc_sum[2], acc_sum[1], acc_sum[0]});
            clear_sums();
        end
    endfunction

    task report_mismatch(string what, logic [47:0] got, logic [47:0] exp_v);
        $display("mismatch %s: got %h expected %h", what, got, exp_v);
        n_err++;
    endtask

    task check_sums(logic [191:0] d, bit flag);
        logic [192:0] x;
        if (sums_q.size() == 0) begin
            $display("unexpected result transaction %h", d);
            n_err++;
            return;
        end
        x = sums_q.pop_front();
        if (d[0 +: 48] !== x[0 +: 48]) report_mismatch("accel_x", d[0 +: 48], x[0 +: 48]);
        if (d[48 +: 48] !== x[48 +: 48]) report_mismatch("accel_y", d[48 +: 48], x[48 +: 48]);
        if (d[96 +: 48] !== x[96 +: 48]) report_mismatch("accel_z", d[96 +: 48], x[96 +: 48]);
        if (d[144 +: 48] !== x[144 +: 48])
            report_mismatch("potential", d[144 +: 48], x[144 +: 48]);
        if (flag !== x[192]) report_mismatch("saturated", 48'(flag), 48'(x[192]));
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIMS = 3;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;    // target_x/y/z, neighbour_x/y/z, neighbour_mass
    logic         s_tlast;    // last_neighbour
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;    // accel_x/y/z, potential
    logic         m_tuser;    // saturated

    int src_idle_pct;
    int sink_idle_pct;
    gravity_sums sums;

    direct_sum_gravity_accumulator_top #(.DIMS(DIMS)) i_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random backpressure, check each result transaction.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sums.check_sums(m_tdata, m_tuser);
    end

    // tvalid stays high after an accepted transaction until the next idle cycle
    // or the next drain, so the next transaction can follow with no gap
    task automatic send_neighbour(logic [223:0] d, bit last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        sums.note_neighbour(d, last);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        while (sums.sums_q.size() != 0) @(negedge aclk);
        repeat (250) @(negedge aclk);
    endtask

    task automatic write_softening(logic [31:0] v);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 0;
        sums.soft_sq = v;
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< $urandom_range(20);
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            default: return $urandom_range(1 << 20);
        endcase
    endfunction

    // One target with a random neighbour list; some close neighbours.
    task automatic send_list(int n);
        logic [95:0] tgt;
        logic [223:0] d;
        tgt = {rand_pos(), rand_pos(), rand_pos()};
        for (int i = 0; i < n; i++) begin
            d = {rand_mass(), rand_pos(), rand_pos(), rand_pos(), tgt};
            if ($urandom_range(9) == 0) d[191:96] = tgt ^ 96'($urandom_range(3));
            send_neighbour(d, i == n - 1);
        end
    endtask

    task automatic random_phase(int n_items);
        int sent, n;
        sent = 0;
        while (sent < n_items) begin
            n = $urandom_range(8, 1);
            send_list(n);
            sent += n;
        end
    endtask

    logic [31:0] soft_vals [4] = '{32'd1, 32'hFFFF_FFFF, 32'd65536, 32'h0000_0100};

    initial begin
        logic [95:0] far_p, near_p;
        sums = new(DIMS);
        aresetn = 0;
        cfg_we = 0;
        cfg_wdata = '0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        m_tready = 0;
        src_idle_pct = 21;
        sink_idle_pct = 62;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: zero distance at reset softening, extremes, mass range
        far_p = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        near_p = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_neighbour({32'hFFFF_FFFF, far_p, far_p}, 1);
        send_neighbour({32'd0, near_p, far_p}, 1);
        send_neighbour({32'hFFFF_FFFF, near_p, far_p}, 0);
        send_neighbour({32'hFFFF_FFFF, far_p, near_p}, 1);
        send_neighbour({32'h0001_0000, 96'h1_0000_0000_0000_0001_0000,
                        96'h0}, 1);
        for (int i = 0; i < 6; i++)
            send_neighbour({32'hFFFF_FFFF, 96'h0000_0001_0000_0000_0000_0000, 96'h0}, i == 5);
        send_neighbour({32'h8000_0000, 96'hFFFF_FFFF_0000_0002_0000_0005, 96'h0}, 1);
        // Pause until every result is back before changing the softening term
        wait_drained();
        write_softening(32'd0);
        send_neighbour({32'hFFFF_FFFF, far_p, far_p}, 1);
        send_neighbour({32'h1234_5678, 96'h1, 96'h0}, 1);
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                src_idle_pct = 62;
                sink_idle_pct = 21;
            end else if (ph == 2) begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            write_softening(soft_vals[ph]);
            random_phase(300);
            wait_drained();
            write_softening(ph == 2 ? soft_vals[3] : $urandom);
            random_phase(280);
            wait_drained();
        end

        if (sums.sums_q.size() == 0 && sums.n_err == 0) begin
            $display("PASS direct_sum_gravity_accumulator_top");
        end else begin
            $display("FAIL direct_sum_gravity_accumulator_top");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL direct_sum_gravity_accumulator_top");
        $finish;
    end
endmodule

`default_nettype wire

[direct_sum_gravity_accumulator_top.f]
rtl/core/dsga_pkg.sv
rtl/core/dsga_mul.sv
rtl/core/dsga_div.sv
rtl/core/dsga_isqrt.sv
rtl/core/direct_sum_gravity_accumulator_top.sv
dv/tb.sv
